### hw/rtl/edfsat_pkg.sv
package edfsat_pkg;

    localparam int MAX_HYPER_DEF = 4096;
    localparam int MAX_JOBS_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int NUM_TASKS_DEF = 3;

    localparam int FIELD_W   = 16;
    localparam int FIELD_MAX = 65535;
    localparam int CFG_W     = 7;

    // register indexes
    localparam int REG_PERIOD_A = 0;
    localparam int REG_EXEC_A   = 1;
    localparam int REG_PERIOD_B = 2;
    localparam int REG_EXEC_B   = 3;
    localparam int REG_PERIOD_C = 4;
    localparam int REG_EXEC_C   = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HYPER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] release_time;
        logic [FIELD_W-1:0] job_exec;
        logic [FIELD_W-1:0] due_time;
    } job_t;

    typedef struct packed {
        logic               accepted;
        logic [FIELD_W-1:0] job_slack;
        logic [1:0]         status;
    } res_t;

    function automatic logic [CFG_W-1:0] cfg_reset(input int idx);
        logic [CFG_W-1:0] v;
        case (idx)
            REG_PERIOD_A: v = 7'd4;
            REG_EXEC_A:   v = 7'd1;
            REG_PERIOD_B: v = 7'd12;
            REG_EXEC_B:   v = 7'd2;
            REG_PERIOD_C: v = 7'd6;
            REG_EXEC_C:   v = 7'd1;
            default:      v = (idx % 2 == 0) ? 7'd1 : 7'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/edf_sporadic_acceptance_test_unit.sv
// EDF sporadic job acceptance test. Three periodic tasks (period and execution set over the
// APB port) are scheduled earliest deadline first over one hyperperiod; the result is kept
// in a RAM as a prefix count of idle slots. Each job transfer returns one result transfer
// with its slack, an accept flag and a status. The first job after reset or after any
// register write rebuilds the map: the lcm of the periods, then one EDF slot per cycle
// over the hyperperiod h (at most MAX_HYPER). A job then gets its own slack from the
// shared serial divider, reads each stored job and works out the slack again for each
// stored job with an equal or later deadline. One job is in work at a time; a finished
// result may wait in the output register while the next job is taken.
module edf_sporadic_acceptance_test_unit
    import edfsat_pkg::*;
#(
    parameter int MAX_HYPER = MAX_HYPER_DEF,
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    localparam int PAW = $clog2(8 * NUM_TASKS)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  job_t           job,
    output logic           res_valid,
    input  logic           res_ready,
    output res_t           res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int NREGS = 2 * NUM_TASKS;
    localparam int TB    = TIME_BITS;
    localparam int HB    = $clog2(MAX_HYPER + 1);
    localparam int HAW   = $clog2(MAX_HYPER);
    localparam int RW    = (HB + 1 > 8) ? HB + 1 : 8;
    localparam int KB    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int JAW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int JCW   = $clog2(MAX_JOBS + 1);
    localparam int SW    = TB + JCW + 1;
    localparam int IW    = PAW - 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LCM_SUB  = 4'd1;
    localparam logic [3:0] S_LCM_WALK = 4'd2;
    localparam logic [3:0] S_SIM_INIT = 4'd3;
    localparam logic [3:0] S_SIM      = 4'd4;
    localparam logic [3:0] S_HFAIL    = 4'd5;
    localparam logic [3:0] S_SL_START = 4'd6;
    localparam logic [3:0] S_SL_DIV   = 4'd7;
    localparam logic [3:0] S_SL_SUM   = 4'd8;
    localparam logic [3:0] S_OWN_CHK  = 4'd9;
    localparam logic [3:0] S_TBL_RD   = 4'd10;
    localparam logic [3:0] S_TBL_WAIT = 4'd11;
    localparam logic [3:0] S_TBL_CHK  = 4'd12;
    localparam logic [3:0] S_TBL_END  = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    localparam logic CALL_OWN = 1'b0;
    localparam logic CALL_JOB = 1'b1;

    // configuration
    logic [CFG_W-1:0] cfg_reg [NREGS];
    logic [CFG_W-1:0] per [NUM_TASKS];
    logic [CFG_W-1:0] exe [NUM_TASKS];
    logic [IW-1:0]    cfg_idx;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PAW-1:2];
    assign cfg_hit = psel && penable && pwrite && (int'(cfg_idx) < NREGS);

    always_comb
    begin
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            per[k] = (cfg_reg[2*k] == '0) ? CFG_W'(1) : cfg_reg[2*k];
            exe[k] = cfg_reg[2*k+1];
        end
        prdata = '0;
        if (int'(cfg_idx) < NREGS)
        begin
            prdata = 32'(cfg_reg[cfg_idx]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                cfg_reg[i] <= cfg_reset(i);
            end
        end
        else if (cfg_hit)
        begin
            cfg_reg[cfg_idx] <= pwdata[CFG_W-1:0];
        end
    end

    // state
    logic [3:0]      state_reg, state_next;
    logic            mapv_reg, mapv_next;
    logic [HB-1:0]   hyp_reg, hyp_next;
    logic [HB-1:0]   idle_tot_reg, idle_tot_next;
    logic [JCW-1:0]  jcnt_reg, jcnt_next;
    logic            res_valid_reg, res_valid_next;
    res_t            res_reg, res_next;

    logic [KB-1:0]   k_reg, k_next;
    logic [HB:0]     m_reg, m_next;
    logic [RW-1:0]   r_reg, r_next;
    logic [CFG_W-1:0] hm_reg, hm_next;
    logic [HB-1:0]   slot_reg, slot_next;
    logic [HB-1:0]   icnt_reg, icnt_next;
    logic [HB:0]     arr_reg [NUM_TASKS];
    logic [HB:0]     arr_next [NUM_TASKS];
    logic [HB:0]     dl_reg [NUM_TASKS];
    logic [HB:0]     dl_next [NUM_TASKS];
    logic [CFG_W-1:0] left_reg [NUM_TASKS];
    logic [CFG_W-1:0] left_next [NUM_TASKS];

    logic [TB-1:0]   rel_reg, rel_next;
    logic [TB-1:0]   ex_reg, ex_next;
    logic [TB-1:0]   due_reg, due_next;
    logic [TB-1:0]   sa_reg, sa_next;
    logic [TB-1:0]   sb_reg, sb_next;
    logic            phase_reg, phase_next;
    logic            caller_reg, caller_next;
    logic [TB-1:0]   ibb_reg, ibb_next;
    logic [TB-1:0]   prod_reg, prod_next;
    logic [TB-1:0]   sl_reg, sl_next;
    logic [TB-1:0]   jsl_reg, jsl_next;
    logic [TB-1:0]   jex_reg, jex_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [JCW-1:0]  i_reg, i_next;
    logic            fail_reg, fail_next;
    logic            acc_reg, acc_next;
    logic [1:0]      st_reg, st_next;

    // divider and memories
    logic            div_start;
    logic [TB-1:0]   div_dividend;
    logic            div_done;
    logic [TB-1:0]   div_quot;
    logic [HB-1:0]   div_rem;

    logic            pram_we;
    logic [HAW-1:0]  pram_waddr;
    logic [HB-1:0]   pram_wdata;
    logic [HAW-1:0]  pram_raddr;
    logic [HB-1:0]   pram_rdata;

    logic            jram_we;
    logic [JAW-1:0]  jram_waddr;
    logic [3*TB-1:0] jram_wdata;
    logic [JAW-1:0]  jram_raddr;
    logic [3*TB-1:0] jram_rdata;

    edfsat_div #(
        .NW (TB),
        .DW (HB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (hyp_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    edfsat_ram #(
        .WIDTH (HB),
        .DEPTH (MAX_HYPER)
    ) u_idle_ram (
        .clk   (clk),
        .we    (pram_we),
        .waddr (pram_waddr),
        .wdata (pram_wdata),
        .raddr (pram_raddr),
        .rdata (pram_rdata)
    );

    edfsat_ram #(
        .WIDTH (3 * TB),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .clk   (clk),
        .we    (jram_we),
        .waddr (jram_waddr),
        .wdata (jram_wdata),
        .raddr (jram_raddr),
        .rdata (jram_rdata)
    );

    // EDF pick for the current slot
    logic          found;
    logic [KB-1:0] pick;
    logic [HB:0]   best;

    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        best  = '0;
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            if (exe[k] != '0 && arr_reg[k] < {1'b0, hyp_reg}
                && arr_reg[k] <= {1'b0, slot_reg})
            begin
                if (!found || dl_reg[k] < best)
                begin
                    found = 1'b1;
                    pick  = KB'(k);
                    best  = dl_reg[k];
                end
            end
        end
    end

    logic [HB:0]     m_sum;
    logic [RW:0]     r_sum;
    logic [TB-1:0]   ib;
    logic [TB-1:0]   j_rel, j_ex, j_due;
    logic [SW-1:0]   need;

    assign m_sum = m_reg + {1'b0, hyp_reg};
    assign r_sum = {1'b0, r_reg} + (RW + 1)'(hm_reg);
    assign ib    = prod_reg + TB'(pram_rdata);
    assign j_rel = jram_rdata[3*TB-1:2*TB];
    assign j_ex  = jram_rdata[2*TB-1:TB];
    assign j_due = jram_rdata[TB-1:0];
    assign need  = sum_reg + SW'(ex_reg);

    assign job_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mapv_next      = mapv_reg;
        hyp_next       = hyp_reg;
        idle_tot_next  = idle_tot_reg;
        jcnt_next      = jcnt_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        r_next         = r_reg;
        hm_next        = hm_reg;
        slot_next      = slot_reg;
        icnt_next      = icnt_reg;
        arr_next       = arr_reg;
        dl_next        = dl_reg;
        left_next      = left_reg;
        rel_next       = rel_reg;
        ex_next        = ex_reg;
        due_next       = due_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        phase_next     = phase_reg;
        caller_next    = caller_reg;
        ibb_next       = ibb_reg;
        prod_next      = prod_reg;
        sl_next        = sl_reg;
        jsl_next       = jsl_reg;
        jex_next       = jex_reg;
        sum_next       = sum_reg;
        i_next         = i_reg;
        fail_next      = fail_reg;
        acc_next       = acc_reg;
        st_next        = st_reg;

        div_start    = 1'b0;
        div_dividend = sb_reg;
        pram_we      = 1'b0;
        pram_waddr   = slot_reg[HAW-1:0];
        pram_wdata   = icnt_reg;
        pram_raddr   = div_rem[HAW-1:0];
        jram_we      = 1'b0;
        jram_waddr   = jcnt_reg[JAW-1:0];
        jram_wdata   = {rel_reg, ex_reg, due_reg};
        jram_raddr   = i_reg[JAW-1:0];

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    rel_next    = TB'(job.release_time);
                    ex_next     = TB'(job.job_exec);
                    due_next    = TB'(job.due_time);
                    sa_next     = TB'(job.release_time);
                    sb_next     = TB'(job.due_time);
                    caller_next = CALL_OWN;
                    if (mapv_reg)
                    begin
                        state_next = S_SL_START;
                    end
                    else
                    begin
                        hyp_next   = HB'(1);
                        k_next     = '0;
                        r_next     = RW'(1);
                        state_next = S_LCM_SUB;
                    end
                end
            end
            S_LCM_SUB:
            begin
                // hyp mod p by repeated subtraction
                if (r_reg >= RW'(per[k_reg]))
                begin
                    r_next = r_reg - RW'(per[k_reg]);
                end
                else
                begin
                    hm_next    = r_reg[CFG_W-1:0];
                    m_next     = {1'b0, hyp_reg};
                    state_next = S_LCM_WALK;
                end
            end
            S_LCM_WALK:
            begin
                if (r_reg == '0)
                begin
                    hyp_next = m_reg[HB-1:0];
                    if (int'(k_reg) == NUM_TASKS - 1)
                    begin
                        state_next = S_SIM_INIT;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        r_next     = RW'(m_reg);
                        state_next = S_LCM_SUB;
                    end
                end
                else if (m_sum > (HB + 1)'(MAX_HYPER))
                begin
                    state_next = S_HFAIL;
                end
                else
                begin
                    m_next = m_sum;
                    if (r_sum >= (RW + 1)'(per[k_reg]))
                    begin
                        r_next = RW'(r_sum - (RW + 1)'(per[k_reg]));
                    end
                    else
                    begin
                        r_next = RW'(r_sum);
                    end
                end
            end
            S_SIM_INIT:
            begin
                for (int k = 0; k < NUM_TASKS; k++)
                begin
                    arr_next[k]  = '0;
                    dl_next[k]   = (HB + 1)'(per[k]);
                    left_next[k] = exe[k];
                end
                slot_next  = '0;
                icnt_next  = '0;
                state_next = S_SIM;
            end
            S_SIM:
            begin
                pram_we = 1'b1;
                if (!found)
                begin
                    icnt_next = icnt_reg + 1'b1;
                end
                else if (left_reg[pick] == CFG_W'(1))
                begin
                    arr_next[pick]  = arr_reg[pick] + (HB + 1)'(per[pick]);
                    dl_next[pick]   = dl_reg[pick] + (HB + 1)'(per[pick]);
                    left_next[pick] = exe[pick];
                end
                else
                begin
                    left_next[pick] = left_reg[pick] - 1'b1;
                end
                if (slot_reg == hyp_reg - 1'b1)
                begin
                    mapv_next     = 1'b1;
                    idle_tot_next = found ? icnt_reg : icnt_reg + 1'b1;
                    state_next    = S_SL_START;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_HFAIL:
            begin
                acc_next   = 1'b0;
                st_next    = ST_HYPER;
                sl_next    = '0;
                state_next = S_FINISH;
            end
            S_SL_START:
            begin
                if (idle_tot_reg == '0 || sb_reg <= sa_reg)
                begin
                    if (caller_reg == CALL_OWN)
                    begin
                        sl_next    = '0;
                        state_next = S_OWN_CHK;
                    end
                    else
                    begin
                        jsl_next   = '0;
                        state_next = S_TBL_CHK;
                    end
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = sb_reg;
                    phase_next   = 1'b0;
                    state_next   = S_SL_DIV;
                end
            end
            S_SL_DIV:
            begin
                if (div_done)
                begin
                    prod_next  = TB'(div_quot * idle_tot_reg);
                    state_next = S_SL_SUM;
                end
            end
            S_SL_SUM:
            begin
                if (!phase_reg)
                begin
                    ibb_next     = ib;
                    phase_next   = 1'b1;
                    div_start    = 1'b1;
                    div_dividend = sa_reg;
                    state_next   = S_SL_DIV;
                end
                else if (caller_reg == CALL_OWN)
                begin
                    sl_next    = ibb_reg - ib;
                    state_next = S_OWN_CHK;
                end
                else
                begin
                    jsl_next   = ibb_reg - ib;
                    state_next = S_TBL_CHK;
                end
            end
            S_OWN_CHK:
            begin
                st_next = ST_OK;
                if (sl_reg < ex_reg)
                begin
                    acc_next   = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    i_next     = '0;
                    sum_next   = '0;
                    fail_next  = 1'b0;
                    state_next = S_TBL_RD;
                end
            end
            S_TBL_RD:
            begin
                if (i_reg == jcnt_reg)
                begin
                    state_next = S_TBL_END;
                end
                else
                begin
                    state_next = S_TBL_WAIT;
                end
            end
            S_TBL_WAIT:
            begin
                if (due_reg > j_due)
                begin
                    sum_next   = sum_reg + SW'(j_ex);
                    i_next     = i_reg + 1'b1;
                    state_next = S_TBL_RD;
                end
                else
                begin
                    sa_next     = j_rel;
                    sb_next     = j_due;
                    jex_next    = j_ex;
                    caller_next = CALL_JOB;
                    state_next  = S_SL_START;
                end
            end
            S_TBL_CHK:
            begin
                if ((TB + 1)'(jsl_reg) < (TB + 1)'(ex_reg) + (TB + 1)'(jex_reg))
                begin
                    fail_next  = 1'b1;
                    state_next = S_TBL_END;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_TBL_RD;
                end
            end
            S_TBL_END:
            begin
                acc_next   = 1'b0;
                st_next    = ST_OK;
                state_next = S_FINISH;
                if (!fail_reg && SW'(sl_reg) >= need)
                begin
                    if (int'(jcnt_reg) >= MAX_JOBS)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        jram_we   = 1'b1;
                        jcnt_next = jcnt_reg + 1'b1;
                        acc_next  = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.accepted  = acc_reg;
                    res_next.status    = st_reg;
                    res_next.job_slack = (sl_reg > TB'(FIELD_MAX))
                                         ? FIELD_W'(FIELD_MAX) : FIELD_W'(sl_reg);
                    res_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_hit)
        begin
            mapv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mapv_reg      <= 1'b0;
            hyp_reg       <= '0;
            idle_tot_reg  <= '0;
            jcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mapv_reg      <= mapv_next;
            hyp_reg       <= hyp_next;
            idle_tot_reg  <= idle_tot_next;
            jcnt_reg      <= jcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        k_reg      <= k_next;
        m_reg      <= m_next;
        r_reg      <= r_next;
        hm_reg     <= hm_next;
        slot_reg   <= slot_next;
        icnt_reg   <= icnt_next;
        arr_reg    <= arr_next;
        dl_reg     <= dl_next;
        left_reg   <= left_next;
        rel_reg    <= rel_next;
        ex_reg     <= ex_next;
        due_reg    <= due_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        phase_reg  <= phase_next;
        caller_reg <= caller_next;
        ibb_reg    <= ibb_next;
        prod_reg   <= prod_next;
        sl_reg     <= sl_next;
        jsl_reg    <= jsl_next;
        jex_reg    <= jex_next;
        sum_reg    <= sum_next;
        i_reg      <= i_next;
        fail_reg   <= fail_next;
        acc_reg    <= acc_next;
        st_reg     <= st_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_jcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(jcnt_reg) <= MAX_JOBS)
        else $error("job count beyond table depth");

    a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.accepted |-> res_reg.status == ST_OK)
        else $error("accepted transfer with error status");

    a_hyper_slack: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status == ST_HYPER |-> res_reg.job_slack == '0)
        else $error("slack reported for oversize hyperperiod");

    a_map_built: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mapv_reg) |-> hyp_reg != '0 && idle_tot_reg <= hyp_reg)
        else $error("idle map built with bad length");

endmodule

### hw/rtl/edfsat_ram.sv
module edfsat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/edfsat_div.sv
module edfsat_div #(
    parameter int NW = 16,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[NW-1]};
        diff      = trial - {1'b0, divisor};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            num_next  = dividend;
            q_next    = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DW-1:0];
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

### tb/sv/edf_sporadic_acceptance_test_unit_tb.sv
module edf_sporadic_acceptance_test_unit_tb;
    import edfsat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAW = $clog2(8 * NUM_TASKS_DEF);
    localparam int MAX_CYCLES = 3000000;
    localparam int NUM_DIRECTED = 14;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           job_valid = 1'b0;
    logic           job_ready;
    job_t           job = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    res_t           res;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [PAW-1:0] paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    edf_sporadic_acceptance_test_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .job      (job),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // scheduler shadow
    logic [6:0]  task_cfg [6];
    bit          slot_idle [MAX_HYPER_DEF];
    int          hyper_len;
    int          idle_count;
    bit          map_built;
    int          tab_rel [MAX_JOBS_DEF];
    int          tab_ex [MAX_JOBS_DEF];
    int          tab_due [MAX_JOBS_DEF];
    int          tab_count;

    res_t        pending_results [$];
    res_t        typed_result [$];
    bit          typed_valid [$];

    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;

    function automatic int eff_period(int k);
        return (task_cfg[2*k] == 0) ? 1 : int'(task_cfg[2*k]);
    endfunction

    function automatic int gcd_of(int a, int b);
        int t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic bit build_idle_map();
        int h;
        int done_cnt [3];
        int left [3];
        int pick;
        int best;
        int p;
        int arr;
        h = 1;
        for (int k = 0; k < 3; k++)
        begin
            p = eff_period(k);
            h = (h / gcd_of(h, p)) * p;
            if (h > MAX_HYPER_DEF)
                return 1'b0;
        end
        for (int k = 0; k < 3; k++)
        begin
            done_cnt[k] = 0;
            left[k] = task_cfg[2*k+1];
        end
        idle_count = 0;
        for (int s = 0; s < h; s++)
        begin
            pick = -1;
            best = 0;
            for (int k = 0; k < 3; k++)
            begin
                p = eff_period(k);
                arr = done_cnt[k] * p;
                if (task_cfg[2*k+1] == 0 || done_cnt[k] >= h / p || arr > s)
                    continue;
                if (pick < 0 || arr + p < best)
                begin
                    pick = k;
                    best = arr + p;
                end
            end
            if (pick < 0)
            begin
                slot_idle[s] = 1'b1;
                idle_count++;
            end
            else
            begin
                slot_idle[s] = 1'b0;
                left[pick]--;
                if (left[pick] == 0)
                begin
                    done_cnt[pick]++;
                    left[pick] = task_cfg[2*pick+1];
                end
            end
        end
        hyper_len = h;
        map_built = 1'b1;
        return 1'b1;
    endfunction

    function automatic longint idle_upto(int x);
        longint c;
        c = longint'(x / hyper_len) * idle_count;
        for (int t = 0; t < x % hyper_len; t++)
            c += slot_idle[t];
        return c;
    endfunction

    function automatic longint window_slack(int rel, int due);
        if (idle_count == 0 || due <= rel)
            return 0;
        return idle_upto(due) - idle_upto(rel);
    endfunction

    function automatic res_t judge_job(job_t j);
        res_t r;
        int rel;
        int ex;
        int due;
        longint sl;
        longint sum;
        bit ok;
        rel = j.release_time;
        ex = j.job_exec;
        due = j.due_time;
        r = '0;
        if (!map_built && !build_idle_map())
        begin
            r.status = ST_HYPER;
            return r;
        end
        sl = window_slack(rel, due);
        sum = 0;
        ok = sl >= ex;
        if (ok)
        begin
            for (int i = 0; i < tab_count; i++)
            begin
                if (due > tab_due[i])
                    sum += tab_ex[i];
                else if (window_slack(tab_rel[i], tab_due[i]) < ex + tab_ex[i])
                    ok = 1'b0;
            end
            if (sl < sum + ex)
                ok = 1'b0;
        end
        r.status = ST_OK;
        if (ok && tab_count >= MAX_JOBS_DEF)
        begin
            ok = 1'b0;
            r.status = ST_FULL;
        end
        if (ok)
        begin
            tab_rel[tab_count] = rel;
            tab_ex[tab_count] = ex;
            tab_due[tab_count] = due;
            tab_count++;
        end
        r.accepted = ok;
        r.job_slack = (sl > FIELD_MAX) ? FIELD_MAX[15:0] : sl[15:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (job_valid && job_ready)
            begin
                pending_results.push_back(judge_job(job));
            end
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer %p", res);
                end
                else
                begin
                    res_t exp_r;
                    exp_r = pending_results.pop_front();
                    if (typed_valid.size() > 0)
                    begin
                        if (typed_valid.pop_front() && typed_result[0] !== exp_r)
                        begin
                            errors++;
                            if (errors <= 10)
                                $display("table row %p disagrees with prediction %p",
                                         typed_result[0], exp_r);
                        end
                        void'(typed_result.pop_front());
                    end
                    if (res.accepted !== exp_r.accepted || res.job_slack !== exp_r.job_slack
                        || res.status !== exp_r.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp acc %0d slack %0d st %0d, got %0d %0d %0d",
                                     exp_r.accepted, exp_r.job_slack, exp_r.status,
                                     res.accepted, res.job_slack, res.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (recv_hold)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_job(job_t j, bit has_typed, res_t typed);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        typed_valid.push_back(has_typed);
        typed_result.push_back(typed);
        job_valid <= 1'b1;
        job <= j;
        @(posedge clk);
        while (!job_ready)
            @(posedge clk);
        job_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() > 0 || job_valid)
            @(posedge clk);
        wait_cycles(5000);
    endtask

    task automatic write_reg(int idx, logic [6:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PAW'(4 * idx);
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        task_cfg[idx] = val;
        map_built = 1'b0;
        @(posedge clk);
    endtask

    task automatic set_tasks(logic [6:0] pa, logic [6:0] ea, logic [6:0] pb,
                             logic [6:0] eb, logic [6:0] pc, logic [6:0] ec);
        drain();
        write_reg(REG_PERIOD_A, pa);
        write_reg(REG_EXEC_A, ea);
        write_reg(REG_PERIOD_B, pb);
        write_reg(REG_EXEC_B, eb);
        write_reg(REG_PERIOD_C, pc);
        write_reg(REG_EXEC_C, ec);
    endtask

    function automatic job_t mk_job(int rel, int ex, int due);
        job_t j;
        j.release_time = 16'(rel);
        j.job_exec = 16'(ex);
        j.due_time = 16'(due);
        return j;
    endfunction

    function automatic res_t mk_res(bit acc, int sl, logic [1:0] st);
        res_t r;
        r.accepted = acc;
        r.job_slack = 16'(sl);
        r.status = st;
        return r;
    endfunction

    task automatic random_jobs(int n);
        int rel;
        int span;
        res_t none;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0: send_job(job_t'(48'({$urandom, $urandom})), 1'b0, none);
                1:
                begin
                    rel = $urandom_range(65535);
                    send_job(mk_job(rel, $urandom_range(3), $urandom_range(rel)), 1'b0, none);
                end
                default:
                begin
                    rel = $urandom_range(65000);
                    span = $urandom_range(400);
                    if ($urandom_range(9) == 0)
                        span = $urandom_range(65535 - rel);
                    send_job(mk_job(rel, $urandom_range(span / 4), rel + span), 1'b0, none);
                end
            endcase
        end
    endtask

    // directed table: flag says whether the expected result column is filled in
    job_t dir_job [NUM_DIRECTED];
    res_t dir_res [NUM_DIRECTED];
    bit   dir_typed [NUM_DIRECTED];

    initial
    begin
        for (int i = 0; i < 6; i++)
            task_cfg[i] = cfg_reset(i);
        map_built = 1'b0;
        tab_count = 0;
        hyper_len = 0;
        idle_count = 0;

        // default set: hyperperiod 12, a=3 b=2 c=2 busy, 5 idle per 12
        dir_job[0]  = mk_job(0, 0, 0);          dir_res[0]  = mk_res(1, 0, ST_OK);
        dir_typed[0] = 1;
        dir_job[1]  = mk_job(100, 0, 50);       dir_res[1]  = mk_res(1, 0, ST_OK);
        dir_typed[1] = 1;
        dir_job[2]  = mk_job(0, 65535, 65535);  dir_typed[2] = 0;
        dir_job[3]  = mk_job(0, 1, 24);         dir_typed[3] = 0;
        dir_job[4]  = mk_job(65535, 0, 65535);  dir_res[4]  = mk_res(1, 0, ST_OK);
        dir_typed[4] = 1;
        dir_job[5]  = mk_job(0, 0, 65535);      dir_typed[5] = 0;
        dir_job[6]  = mk_job(10, 3, 40);        dir_typed[6] = 0;
        dir_job[7]  = mk_job(12, 4, 24);        dir_typed[7] = 0;
        dir_job[8]  = mk_job(5, 2, 7);          dir_typed[8] = 0;
        for (int i = 9; i < NUM_DIRECTED; i++)
        begin
            dir_job[i] = mk_job(1000 * i, 1, 1000 * i + 60);
            dir_typed[i] = 0;
        end

        wait_cycles(10);
        rst_n <= 1'b1;
        wait_cycles(2);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_job(dir_job[i], dir_typed[i], dir_res[i]);

        // fill the table to reach the full status
        for (int i = 0; i < 12; i++)
            send_job(mk_job(2000 + 100 * i, 0, 2050 + 100 * i), 1'b0, '0);

        // hyperperiod too large: 64,63,61
        set_tasks(7'd64, 7'd1, 7'd63, 7'd1, 7'd61, 7'd1);
        send_job(mk_job(0, 0, 100), 1'b1, mk_res(0, 0, ST_HYPER));

        // fully busy: period 1, exec 1, and zero period; table already full
        set_tasks(7'd1, 7'd1, 7'd0, 7'd0, 7'd1, 7'd0);
        send_job(mk_job(0, 0, 1000), 1'b1, mk_res(0, 0, ST_FULL));

        // extreme: largest periods with sane lcm, exec 64 and 127 beyond range
        set_tasks(7'd64, 7'd64, 7'd32, 7'd0, 7'd64, 7'd127);

        send_idle_pct = 28;
        recv_idle_pct = 57;
        random_jobs(40);

        set_tasks(7'd8, 7'd2, 7'd16, 7'd3, 7'd4, 7'd1);
        send_idle_pct = 57;
        recv_idle_pct = 28;
        random_jobs(40);

        // long receiver hold-off while jobs keep arriving
        recv_hold = 1'b1;
        fork
            random_jobs(8);
            begin
                wait_cycles(3000);
                recv_hold = 1'b0;
            end
        join

        set_tasks(7'd5, 7'd1, 7'd7, 7'd2, 7'd3, 7'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_jobs(26);

        drain();
        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
